[rtl/core/swg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swg_pkg
// Shared widths, constants and the sine table of the scaled waveform generator.
// ----------------------------------------------------------------------------
package swg_pkg;

    localparam int TABLE_POINTS = 50;
    localparam int HALF_POINTS  = 25;

    localparam int PHASE_W    = 6;
    localparam int CODE_W     = 12;
    localparam int CNT_W      = 23;
    localparam int SHAPE_W    = 2;
    localparam int VPP_W      = 17;
    localparam int FREQ_W     = 16;
    localparam int VEFF_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int DIV_W      = 27;
    localparam int DEN_W      = 16;
    localparam int DIV_CNT_W  = 5;
    localparam int RCP_W      = 28;
    localparam int RCP_SHIFT  = 42;
    localparam int QUO_W      = DIV_W + RCP_W - RCP_SHIFT;

    localparam logic [VEFF_W-1:0] VPP_MAX      = 15'd19800;
    localparam logic [VPP_W-1:0]  VPP_MAX_REQ  = 17'd19800;
    localparam logic [VPP_W-1:0]  ATTEN_LIMIT  = 17'd900;
    localparam logic [VEFF_W-1:0] ATTEN_LIMIT_V = 15'd900;
    localparam logic [VEFF_W-1:0] ATTEN_GAIN   = 15'd20;
    localparam logic [CODE_W-1:0] CODE_MAX     = 12'd4095;
    localparam logic [DEN_W-1:0]  DEN_VPP      = 16'd19800;
    localparam logic [DEN_W-1:0]  DEN_HALF_PTS = 16'd25;
    localparam logic [DEN_W-1:0]  DEN_ONE      = 16'd1;
    localparam logic [DEN_W-1:0]  TRI_SCALE    = DEN_VPP / DEN_HALF_PTS;
    // reciprocal of 19800, exact for dividends below 2**27
    localparam logic [RCP_W-1:0]  RCP_VPP      =
        RCP_W'(((64'd1 << RCP_SHIFT) + 64'(DEN_VPP) - 64'd1) / 64'(DEN_VPP));
    localparam logic [DIV_W-1:0]  TICKS_PER_CYCLE  = 27'd4800000;
    localparam logic [DIV_W-1:0]  TICKS_PER_CYCLE_C = 27'd48000;
    localparam logic [FREQ_W-1:0] LOW_FREQ     = 16'd100;
    localparam logic [CNT_W-1:0]  LOW_FREQ_MUL = 23'd100;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd27;

    localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SHAPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VPP_REQUEST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_HZ     = 2'd2;

    localparam logic [CODE_W-1:0] SINE_TABLE [TABLE_POINTS] = '{
        12'd2048, 12'd2304, 12'd2557, 12'd2801, 12'd3034, 12'd3251, 12'd3449, 12'd3625,
        12'd3776, 12'd3900, 12'd3995, 12'd4059, 12'd4091, 12'd4091, 12'd4059, 12'd3995,
        12'd3900, 12'd3776, 12'd3625, 12'd3449, 12'd3251, 12'd3034, 12'd2801, 12'd2557,
        12'd2304, 12'd2048, 12'd1791, 12'd1538, 12'd1294, 12'd1061, 12'd844,  12'd646,
        12'd470,  12'd319,  12'd195,  12'd100,  12'd36,   12'd4,    12'd4,    12'd36,
        12'd100,  12'd195,  12'd319,  12'd470,  12'd646,  12'd844,  12'd1061, 12'd1294,
        12'd1538, 12'd1791
    };

endpackage

[rtl/core/swg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swg_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 50
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/scaled_waveform_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_waveform_generator
// 50-point sine/square/triangle DAC code source with amplitude scaling.
// ----------------------------------------------------------------------------
// One transaction on the s_ channel is one base-clock tick; each yields one
// result transaction, passing the registered RAM read and the output
// register, and a new tick is taken every cycle while the m_ side keeps up.
// The scaled waveform lives in a 50-entry code RAM read once per tick. After
// reset and after every write to a defined register the block rebuilds the
// sample period and the code RAM: one bit-serial division for the period,
// then the offset, the full-scale level and the 50 table points, whose
// constant divisions use a reciprocal multiplication; during the rebuild
// s_ready and cfg_ready are low.
// ----------------------------------------------------------------------------
module scaled_waveform_generator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_tick,
    input  logic                              s_run,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [swg_pkg::CODE_W-1:0]        m_dac_code,
    output logic                              m_sample_strobe,
    output logic [swg_pkg::PHASE_W-1:0]       m_phase_index,
    output logic                              m_attenuator_on,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import swg_pkg::*;

    typedef enum logic [4:0] {
        ST_PERIOD = 5'b00001,
        ST_OFFSET = 5'b00010,
        ST_SCALE  = 5'b00100,
        ST_POINT  = 5'b01000,
        ST_RUN    = 5'b10000
    } fsm_t;

    fsm_t fsm_reg, fsm_next;

    logic [SHAPE_W-1:0] shape_reg;
    logic [VPP_W-1:0]   vpp_reg;
    logic [FREQ_W-1:0]  freq_reg;

    logic [CNT_W-1:0]   period_reg, period_next;
    logic [CODE_W-1:0]  offset_reg, offset_next;
    logic [CODE_W-1:0]  high_reg, high_next;
    logic [PHASE_W-1:0] fill_idx_reg, fill_idx_next;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   tick_cnt_reg, tick_cnt_next;

    logic               pend_reg, pend_next;
    logic               pend_strobe_reg, pend_strobe_next;
    logic [PHASE_W-1:0] pend_phase_reg;
    logic               pend_atten_reg;

    logic               m_valid_reg, m_valid_next;
    logic [CODE_W-1:0]  m_code_reg;
    logic               m_strobe_reg;
    logic [PHASE_W-1:0] m_phase_reg;
    logic               m_atten_reg;

    logic                 div_pend_reg, div_pend_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [DIV_W-1:0]     div_quo_reg, div_quo_next;
    logic [DEN_W-1:0]     div_rem_reg, div_rem_next;
    logic [DEN_W-1:0]     div_den_reg, div_den_next;
    logic                 div_load;
    logic [DIV_W-1:0]     div_dividend;
    logic [DEN_W-1:0]     div_divisor;
    logic [DEN_W:0]       div_trial;
    logic                 div_ge;

    logic [DIV_W-1:0]       rcp_num_reg, rcp_num_next;
    logic [DIV_W+RCP_W-1:0] rcp_prod;
    logic [QUO_W-1:0]       rcp_quo;

    logic [VEFF_W-1:0]  vclamp, veff, vdiff;
    logic [CODE_W-1:0]  span, quo_code, sine_s;
    logic [4:0]         tri_k;
    logic [DEN_W-1:0]   tri_mul;
    logic [CNT_W:0]     cnt_inc;
    logic               period_hit;
    logic [FREQ_W-1:0]  q16;
    logic [CNT_W-1:0]   period_calc;

    logic               accept, cfg_acc, out_load;
    logic               ram_we;
    logic [CODE_W-1:0]  ram_wdata, ram_rdata;

    assign vclamp = (vpp_reg >= VPP_MAX_REQ) ? VPP_MAX : vpp_reg[VEFF_W-1:0];
    assign veff   = (vclamp <= ATTEN_LIMIT_V) ? VEFF_W'(vclamp * ATTEN_GAIN) : vclamp;
    assign vdiff  = VPP_MAX - veff;
    assign span   = high_reg - offset_reg;
    assign tri_k  = (fill_idx_reg < PHASE_W'(HALF_POINTS))
                    ? fill_idx_reg[4:0] : 5'(fill_idx_reg - PHASE_W'(HALF_POINTS));
    assign tri_mul = DEN_W'(tri_k) * TRI_SCALE;

    // numerator / 19800 by reciprocal multiplication
    assign rcp_prod = (DIV_W+RCP_W)'(rcp_num_reg) * (DIV_W+RCP_W)'(RCP_VPP);
    assign rcp_quo  = rcp_prod[DIV_W+RCP_W-1:RCP_SHIFT];
    assign quo_code = rcp_quo[CODE_W-1:0];
    assign sine_s   = (rcp_quo > QUO_W'(CODE_MAX)) ? CODE_MAX : quo_code;
    assign q16      = div_quo_reg[FREQ_W-1:0];

    always_comb begin
        if (freq_reg < LOW_FREQ) begin
            period_calc = CNT_W'(CNT_W'(q16) * LOW_FREQ_MUL);
        end else begin
            period_calc = CNT_W'(q16);
        end
        if (period_calc == '0) begin
            period_calc = CNT_W'(1);
        end
    end

    assign out_load  = pend_reg && (!m_valid_reg || m_ready);
    assign s_ready   = (fsm_reg == ST_RUN) && (!pend_reg || out_load);
    assign cfg_ready = (fsm_reg == ST_RUN);
    assign accept    = s_valid && s_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign cnt_inc    = {1'b0, tick_cnt_reg} + (CNT_W+1)'(1);
    assign period_hit = cnt_inc >= {1'b0, period_reg};

    // sequencer and tick datapath
    always_comb begin
        fsm_next         = fsm_reg;
        period_next      = period_reg;
        offset_next      = offset_reg;
        high_next        = high_reg;
        fill_idx_next    = fill_idx_reg;
        phase_next       = phase_reg;
        tick_cnt_next    = tick_cnt_reg;
        pend_strobe_next = pend_strobe_reg;
        div_pend_next    = div_pend_reg;
        div_load         = 1'b0;
        div_dividend     = '0;
        div_divisor      = DEN_ONE;
        rcp_num_next     = rcp_num_reg;
        ram_we           = 1'b0;
        ram_wdata        = '0;

        unique case (fsm_reg)
            ST_PERIOD: begin
                if (!div_pend_reg) begin
                    div_load      = 1'b1;
                    div_pend_next = 1'b1;
                    div_dividend  = (freq_reg < LOW_FREQ) ? TICKS_PER_CYCLE_C : TICKS_PER_CYCLE;
                    div_divisor   = (freq_reg == '0) ? DEN_ONE : freq_reg;
                end else if (div_cnt_reg == '0) begin
                    div_pend_next = 1'b0;
                    period_next   = period_calc;
                    fsm_next      = ST_OFFSET;
                end
            end
            ST_OFFSET: begin
                if (!div_pend_reg) begin
                    div_pend_next = 1'b1;
                    rcp_num_next  = (DIV_W'(vdiff) * DIV_W'(CODE_MAX)) >> 1;
                end else begin
                    div_pend_next = 1'b0;
                    offset_next   = quo_code;
                    fsm_next      = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (!div_pend_reg) begin
                    div_pend_next = 1'b1;
                    rcp_num_next  = DIV_W'(veff) * DIV_W'(CODE_MAX);
                end else begin
                    div_pend_next = 1'b0;
                    high_next     = quo_code + offset_reg;
                    fill_idx_next = '0;
                    fsm_next      = ST_POINT;
                end
            end
            ST_POINT: begin
                if (!div_pend_reg) begin
                    div_pend_next = 1'b1;
                    if (shape_reg == SHAPE_SQUARE) begin
                        rcp_num_next = '0;
                    end else if (shape_reg == SHAPE_TRIANGLE) begin
                        rcp_num_next = DIV_W'(span) * DIV_W'(tri_mul);
                    end else begin
                        rcp_num_next = DIV_W'(SINE_TABLE[fill_idx_reg]) * DIV_W'(veff);
                    end
                end else begin
                    div_pend_next = 1'b0;
                    ram_we        = 1'b1;
                    if (shape_reg == SHAPE_SQUARE) begin
                        ram_wdata = (fill_idx_reg < PHASE_W'(HALF_POINTS)) ? offset_reg : high_reg;
                    end else if (shape_reg == SHAPE_TRIANGLE) begin
                        ram_wdata = (fill_idx_reg < PHASE_W'(HALF_POINTS))
                                    ? offset_reg + quo_code : high_reg - quo_code;
                    end else begin
                        ram_wdata = sine_s + offset_reg;
                    end
                    if (fill_idx_reg == PHASE_W'(TABLE_POINTS - 1)) begin
                        fill_idx_next = '0;
                        fsm_next      = ST_RUN;
                    end else begin
                        fill_idx_next = fill_idx_reg + PHASE_W'(1);
                    end
                end
            end
            ST_RUN: begin
                if (accept) begin
                    pend_strobe_next = 1'b0;
                    if (!s_run) begin
                        phase_next    = '0;
                        tick_cnt_next = '0;
                    end else if (s_tick) begin
                        if (period_hit) begin
                            tick_cnt_next    = '0;
                            pend_strobe_next = 1'b1;
                            phase_next = (phase_reg == PHASE_W'(TABLE_POINTS - 1))
                                         ? '0 : phase_reg + PHASE_W'(1);
                        end else begin
                            tick_cnt_next = cnt_inc[CNT_W-1:0];
                        end
                    end
                end
                if (cfg_acc && (cfg_index == CFG_WAVE_SHAPE || cfg_index == CFG_VPP_REQUEST
                                || cfg_index == CFG_FREQ_HZ)) begin
                    fsm_next = ST_PERIOD;
                end
            end
            default: begin
                fsm_next = ST_PERIOD;
            end
        endcase
    end

    // restoring divider, one quotient bit per cycle
    always_comb begin
        div_trial    = {div_rem_reg, div_quo_reg[DIV_W-1]};
        div_ge       = div_trial >= {1'b0, div_den_reg};
        div_cnt_next = div_cnt_reg;
        div_quo_next = div_quo_reg;
        div_rem_next = div_rem_reg;
        div_den_next = div_den_reg;
        if (div_load) begin
            div_cnt_next = DIV_STEPS;
            div_quo_next = div_dividend;
            div_rem_next = '0;
            div_den_next = div_divisor;
        end else if (div_cnt_reg != '0) begin
            div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
            div_quo_next = {div_quo_reg[DIV_W-2:0], div_ge};
            div_rem_next = div_ge ? DEN_W'(div_trial - {1'b0, div_den_reg})
                                  : div_trial[DEN_W-1:0];
        end
    end

    assign pend_next    = accept ? 1'b1 : (out_load ? 1'b0 : pend_reg);
    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= ST_PERIOD;
            shape_reg    <= SHAPE_SINE;
            vpp_reg      <= 17'd10000;
            freq_reg     <= 16'd1000;
            phase_reg    <= '0;
            tick_cnt_reg <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            div_pend_reg <= 1'b0;
            div_cnt_reg  <= '0;
            fill_idx_reg <= '0;
        end else begin
            fsm_reg      <= fsm_next;
            phase_reg    <= phase_next;
            tick_cnt_reg <= tick_cnt_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
            div_pend_reg <= div_pend_next;
            div_cnt_reg  <= div_cnt_next;
            fill_idx_reg <= fill_idx_next;
            if (cfg_acc) begin
                unique case (cfg_index)
                    CFG_WAVE_SHAPE:  shape_reg <= cfg_data[SHAPE_W-1:0];
                    CFG_VPP_REQUEST: vpp_reg   <= cfg_data[VPP_W-1:0];
                    CFG_FREQ_HZ:     freq_reg  <= cfg_data[FREQ_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        period_reg   <= period_next;
        offset_reg   <= offset_next;
        high_reg     <= high_next;
        div_quo_reg  <= div_quo_next;
        div_rem_reg  <= div_rem_next;
        div_den_reg  <= div_den_next;
        rcp_num_reg  <= rcp_num_next;
        if (accept) begin
            pend_strobe_reg <= pend_strobe_next;
            pend_phase_reg  <= phase_next;
            pend_atten_reg  <= (vpp_reg <= ATTEN_LIMIT);
        end
        if (out_load) begin
            m_code_reg   <= ram_rdata;
            m_strobe_reg <= pend_strobe_reg;
            m_phase_reg  <= pend_phase_reg;
            m_atten_reg  <= pend_atten_reg;
        end
    end

    swg_ram #(
        .WIDTH(CODE_W),
        .DEPTH(TABLE_POINTS)
    ) u_code_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (fill_idx_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (phase_next),
        .rdata (ram_rdata)
    );

    assign m_valid         = m_valid_reg;
    assign m_dac_code      = m_code_reg;
    assign m_sample_strobe = m_strobe_reg;
    assign m_phase_index   = m_phase_reg;
    assign m_attenuator_on = m_atten_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (fsm_reg == ST_RUN))
        else $error("tick transaction taken while code table is rebuilt");

    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg < PHASE_W'(TABLE_POINTS))
        else $error("phase out of table range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_run) |=> (phase_reg == '0 && tick_cnt_reg == '0))
        else $error("stop did not clear phase and counter");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_acc && cfg_index == CFG_FREQ_HZ) |=> (fsm_reg == ST_PERIOD && !s_ready))
        else $error("frequency write did not start a rebuild");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("pending result lost");
`endif

endmodule
